>>> rtl/core/fbst_pkg.sv
`default_nettype none
package fbst_pkg;

  localparam int ID_W       = 64;
  localparam int PIX_W      = 32;
  localparam int DIM_W      = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int HELD_W     = 4;
  localparam int FLIGHT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_PRESENT    = 2'd2,
    CMD_COMPLETE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_PROTO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } fsm_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 2'd2;

  localparam logic [PIX_W-1:0] PIXEL_BUDGET_RST = 32'd67108864;
  localparam logic [DIM_W-1:0] MAX_DIM_RST      = 16'd16384;

endpackage
`default_nettype wire

>>> rtl/core/fbst_if.sv
`default_nettype none
interface fbst_in_if import fbst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  buffer_ident;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [ID_W-1:0]  frame_serial;
  logic [ID_W-1:0]  released_ident;

  modport source (output valid, command, buffer_ident, frame_width, frame_height,
                  frame_serial, released_ident, input ready);
  modport sink   (input valid, command, buffer_ident, frame_width, frame_height,
                  frame_serial, released_ident, output ready);
endinterface

interface fbst_out_if import fbst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HELD_W-1:0]   buffers_held;
  logic [FLIGHT_W-1:0] frames_in_flight;
  logic [PIX_W-1:0]    pixels_held;

  modport source (output valid, status, buffers_held, frames_in_flight, pixels_held,
                  input ready);
  modport sink   (input valid, status, buffers_held, frames_in_flight, pixels_held,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/fbst_ram.sv
`default_nettype none
module fbst_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 96,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/frame_buffer_session_tracker_core.sv
`default_nettype none
// Frame buffer session tracker. Keeps a table of registered display buffers
// (id, pixel count) and a table of frames in flight (serial, buffer id), both
// in single-port-read synchronous RAMs. Each accepted item is one command
// (register, unregister, present, complete) and yields exactly one result:
// status plus buffer count, in-flight count and pixel total after the command.
// A failing command changes nothing. Removal compacts a table by copying its
// last entry into the freed slot. Each item is handled by a linear RAM scan
// that reads both tables one entry per cycle over max(buffers held, frames in
// flight) entries. The next item is accepted while a result is still waiting
// on the output register. Configuration writes land immediately; write them
// only while the block is idle.
module frame_buffer_session_tracker_core
  import fbst_pkg::*;
#(
  parameter int BUFFER_SLOTS   = 8,
  parameter int INFLIGHT_SLOTS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fbst_in_if.sink                    in_chan,
  fbst_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int BAW    = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam int FAW    = (INFLIGHT_SLOTS > 1) ? $clog2(INFLIGHT_SLOTS) : 1;
  localparam int BCW    = $clog2(BUFFER_SLOTS + 1);
  localparam int FCW    = $clog2(INFLIGHT_SLOTS + 1);
  localparam int MAXS   = (BUFFER_SLOTS > INFLIGHT_SLOTS) ? BUFFER_SLOTS : INFLIGHT_SLOTS;
  localparam int SCW    = $clog2(MAXS + 1);
  localparam int BENT_W = ID_W + PIX_W;   // {id, pixels}
  localparam int FENT_W = ID_W + ID_W;    // {serial, buffer id}

  // ---------------- configuration ----------------
  logic [PIX_W-1:0] budget_r;
  logic [DIM_W-1:0] maxw_r, maxh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= PIXEL_BUDGET_RST;
      maxw_r   <= MAX_DIM_RST;
      maxh_r   <= MAX_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PIXEL_BUDGET: budget_r <= cfg_wdata[PIX_W-1:0];
        CFG_MAX_WIDTH:    maxw_r   <= cfg_wdata[DIM_W-1:0];
        CFG_MAX_HEIGHT:   maxh_r   <= cfg_wdata[DIM_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------- state ----------------
  fsm_t state_r, state_nxt;

  logic [BCW-1:0]   bcount_r, bcount_nxt;
  logic [FCW-1:0]   fcount_r, fcount_nxt;
  logic [PIX_W-1:0] total_r, total_nxt;

  // latched command
  cmd_t             cmd_r;
  logic [ID_W-1:0]  ident_r, serial_r, rel_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [PIX_W-1:0] px_r;

  // scan pipeline: read issue at idx_r, compare in the next cycle
  logic [SCW-1:0]   idx_r, cmp_idx_r, scan_len;
  logic             cmp_bv_r, cmp_fv_r;
  logic             issue, b_re, f_re;

  // scan results
  logic             bhit_r, relhit_r, fbufhit_r, shit_r, sbuf_ok_r;
  logic [BAW-1:0]   bpos_r;
  logic [FAW-1:0]   spos_r;
  logic [PIX_W-1:0] bpix_r;
  logic [BENT_W-1:0] blast_r;
  logic [FENT_W-1:0] flast_r;

  // RAM ports
  logic              b_we, f_we;
  logic [BAW-1:0]    b_waddr;
  logic [FAW-1:0]    f_waddr;
  logic [BENT_W-1:0] b_wdata, b_rdata;
  logic [FENT_W-1:0] f_wdata, f_rdata;

  // decision
  logic      ok, out_load, accept, sum_fits;
  status_t   status;
  logic [PIX_W:0] sum_px;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [HELD_W-1:0]   out_held_r;
  logic [FLIGHT_W-1:0] out_flight_r;
  logic [PIX_W-1:0]    out_pix_r;

  fbst_ram #(.DEPTH(BUFFER_SLOTS), .WIDTH(BENT_W)) u_buf_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (idx_r[BAW-1:0]),
    .rdata (b_rdata)
  );

  fbst_ram #(.DEPTH(INFLIGHT_SLOTS), .WIDTH(FENT_W)) u_flight_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (idx_r[FAW-1:0]),
    .rdata (f_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_DECIDE) && (!out_valid_r || out_chan.ready);

  assign scan_len = (SCW'(bcount_r) > SCW'(fcount_r)) ? SCW'(bcount_r) : SCW'(fcount_r);
  assign issue    = (state_r == S_SCAN) && (idx_r < scan_len);
  assign b_re     = issue && (idx_r < SCW'(bcount_r));
  assign f_re     = issue && (idx_r < SCW'(fcount_r));

  // no wrap on the budget check: a budget below the total rejects every register
  assign sum_px   = {1'b0, px_r} + {1'b0, total_r};
  assign sum_fits = sum_px <= {1'b0, budget_r};

  // ---------------- control ----------------
  always_comb begin
    state_nxt  = state_r;
    ok         = 1'b0;
    status     = ST_OK;
    b_we       = 1'b0;
    f_we       = 1'b0;
    b_waddr    = bpos_r;
    f_waddr    = spos_r;
    b_wdata    = blast_r;
    f_wdata    = flast_r;
    bcount_nxt = bcount_r;
    fcount_nxt = fcount_r;
    total_nxt  = total_r;

    case (cmd_r)
      CMD_REGISTER: begin
        ok = (ident_r != '0) && (w_r != '0) && (h_r != '0) &&
             (w_r <= maxw_r) && (h_r <= maxh_r) &&
             (bcount_r < BCW'(BUFFER_SLOTS)) && !bhit_r && sum_fits;
        status = ok ? ST_OK : ST_INVALID;
      end
      CMD_UNREGISTER: begin
        ok     = bhit_r && !fbufhit_r;
        status = ok ? ST_OK : ST_BUSY;
      end
      CMD_PRESENT: begin
        ok = (serial_r != '0) && bhit_r && (fcount_r < FCW'(INFLIGHT_SLOTS)) && !shit_r;
        status = ok ? ST_OK : ST_INVALID;
      end
      CMD_COMPLETE: begin
        ok = bhit_r && ((rel_r == '0) || relhit_r) && shit_r && sbuf_ok_r;
        status = ok ? ST_OK : ST_PROTO;
      end
      default: begin
        ok     = 1'b0;
        status = ST_PROTO;
      end
    endcase

    // table updates land only when the result goes into the output register
    if (out_load && ok) begin
      case (cmd_r)
        CMD_REGISTER: begin
          b_we       = 1'b1;
          b_waddr    = bcount_r[BAW-1:0];
          b_wdata    = {ident_r, px_r};
          bcount_nxt = bcount_r + BCW'(1);
          total_nxt  = total_r + px_r;
        end
        CMD_UNREGISTER: begin
          // move last entry into the hole (self-copy when it is the last)
          b_we       = 1'b1;
          bcount_nxt = bcount_r - BCW'(1);
          total_nxt  = total_r - bpix_r;
        end
        CMD_PRESENT: begin
          f_we       = 1'b1;
          f_waddr    = fcount_r[FAW-1:0];
          f_wdata    = {serial_r, ident_r};
          fcount_nxt = fcount_r + FCW'(1);
        end
        CMD_COMPLETE: begin
          f_we       = 1'b1;
          fcount_nxt = fcount_r - FCW'(1);
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (!issue) state_nxt = S_DECIDE;
      S_DECIDE: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bcount_r <= '0;
      fcount_r <= '0;
      total_r  <= '0;
      cmp_bv_r <= 1'b0;
      cmp_fv_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bcount_r <= bcount_nxt;
      fcount_r <= fcount_nxt;
      total_r  <= total_nxt;
      cmp_bv_r <= b_re;
      cmp_fv_r <= f_re;
    end
  end

  // command latch and scan bookkeeping
  always_ff @(posedge clk) begin
    px_r <= PIX_W'(w_r) * PIX_W'(h_r);
    if (accept) begin
      cmd_r     <= cmd_t'(in_chan.command);
      ident_r   <= in_chan.buffer_ident;
      w_r       <= in_chan.frame_width;
      h_r       <= in_chan.frame_height;
      serial_r  <= in_chan.frame_serial;
      rel_r     <= in_chan.released_ident;
      idx_r     <= '0;
      bhit_r    <= 1'b0;
      relhit_r  <= 1'b0;
      fbufhit_r <= 1'b0;
      shit_r    <= 1'b0;
      sbuf_ok_r <= 1'b0;
    end else begin
      if (issue) begin
        idx_r <= idx_r + SCW'(1);
      end
      cmp_idx_r <= idx_r;

      if (cmp_bv_r) begin
        if (b_rdata[BENT_W-1:PIX_W] == ident_r && !bhit_r) begin
          bhit_r <= 1'b1;
          bpos_r <= cmp_idx_r[BAW-1:0];
          bpix_r <= b_rdata[PIX_W-1:0];
        end
        if (b_rdata[BENT_W-1:PIX_W] == rel_r) begin
          relhit_r <= 1'b1;
        end
        if ((cmp_idx_r + SCW'(1)) == SCW'(bcount_r)) begin
          blast_r <= b_rdata;
        end
      end

      if (cmp_fv_r) begin
        if (f_rdata[ID_W-1:0] == ident_r) begin
          fbufhit_r <= 1'b1;
        end
        if (f_rdata[FENT_W-1:ID_W] == serial_r && !shit_r) begin
          shit_r    <= 1'b1;
          spos_r    <= cmp_idx_r[FAW-1:0];
          sbuf_ok_r <= (f_rdata[ID_W-1:0] == ident_r);
        end
        if ((cmp_idx_r + SCW'(1)) == SCW'(fcount_r)) begin
          flast_r <= f_rdata;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status;
      out_held_r   <= HELD_W'(bcount_nxt);
      out_flight_r <= FLIGHT_W'(fcount_nxt);
      out_pix_r    <= total_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.buffers_held     = out_held_r;
  assign out_chan.frames_in_flight = out_flight_r;
  assign out_chan.pixels_held      = out_pix_r;

  // ---------------- assertions ----------------
  a_bcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    bcount_r <= BCW'(BUFFER_SLOTS))
    else $error("buffer count above table size");

  a_fcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcount_r <= FCW'(INFLIGHT_SLOTS))
    else $error("in-flight count above table size");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    (b_we || f_we) |-> (out_load && !(b_we && f_we)))
    else $error("table write outside result load");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECIDE) |=> ($stable(total_r) && $stable(bcount_r) && $stable(fcount_r)))
    else $error("tracker state changed outside decision");

endmodule
`default_nettype wire

>>> tb/frame_buffer_session_tracker_core_test.sv
`default_nettype none
module frame_buffer_session_tracker_core_test;
  import fbst_pkg::*;

  localparam int BUFFER_SLOTS   = 8;
  localparam int INFLIGHT_SLOTS = 4;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 32;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTS    = 10;
  localparam int IDENT_POOL     = 10;
  localparam int SERIAL_POOL    = 6;

  // index 3 decodes to nothing; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam logic [ID_W-1:0] ID_TOP = '1;

  typedef struct packed {
    cmd_t             command;
    logic [ID_W-1:0]  buffer_ident;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [ID_W-1:0]  frame_serial;
    logic [ID_W-1:0]  released_ident;
  } command_item_t;

  typedef struct packed {
    status_t             status;
    logic [HELD_W-1:0]   buffers_held;
    logic [FLIGHT_W-1:0] frames_in_flight;
    logic [PIX_W-1:0]    pixels_held;
  } session_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fbst_in_if  in_if();
  fbst_out_if out_if();

  frame_buffer_session_tracker_core #(
    .BUFFER_SLOTS  (BUFFER_SLOTS),
    .INFLIGHT_SLOTS(INFLIGHT_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the tracker: buffer table, in-flight table and limits.
  // Updated at the edge where an item or a register write is taken.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]  held_ident  [BUFFER_SLOTS];
  logic [PIX_W-1:0] held_pixels [BUFFER_SLOTS];
  int               held_count;
  logic [PIX_W-1:0] pixel_sum;
  logic [ID_W-1:0]  flight_serial [INFLIGHT_SLOTS];
  logic [ID_W-1:0]  flight_ident  [INFLIGHT_SLOTS];
  int               flight_count;
  logic [PIX_W-1:0] budget_lim;
  logic [DIM_W-1:0] width_lim;
  logic [DIM_W-1:0] height_lim;

  command_item_t   pending_commands[$];
  session_result_t expected_results[$];

  logic [ID_W-1:0] ident_pool  [IDENT_POOL];
  logic [ID_W-1:0] serial_pool [SERIAL_POOL];

  int mismatch_count;

  // position of a registered id, -1 when absent
  function automatic int buffer_slot(logic [ID_W-1:0] ident);
    for (int i = 0; i < held_count; i++) begin
      if (held_ident[i] == ident) return i;
    end
    return -1;
  endfunction

  function automatic int serial_slot(logic [ID_W-1:0] serial);
    for (int i = 0; i < flight_count; i++) begin
      if (flight_serial[i] == serial) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow state and return the status/counters the
  // block must report. Failing commands leave the state alone.
  function automatic session_result_t predict_session_result(command_item_t c);
    status_t         st;
    int              pos;
    int              last;
    bit              busy;
    logic [PIX_W-1:0] px;
    logic [PIX_W:0]   total_after;
    session_result_t r;
    st = ST_OK;
    case (c.command)
      CMD_REGISTER: begin
        px = c.frame_width * c.frame_height;
        // one extra bit so the budget compare never wraps
        total_after = {1'b0, px} + {1'b0, pixel_sum};
        if (c.buffer_ident == '0 || c.frame_width == '0 || c.frame_height == '0 ||
            c.frame_width > width_lim || c.frame_height > height_lim ||
            held_count >= BUFFER_SLOTS || buffer_slot(c.buffer_ident) >= 0 ||
            total_after > {1'b0, budget_lim}) begin
          st = ST_INVALID;
        end else begin
          held_ident[held_count]  = c.buffer_ident;
          held_pixels[held_count] = px;
          held_count++;
          pixel_sum = pixel_sum + px;
        end
      end
      CMD_UNREGISTER: begin
        pos  = buffer_slot(c.buffer_ident);
        busy = (pos < 0);
        for (int i = 0; i < flight_count; i++) begin
          if (flight_ident[i] == c.buffer_ident) busy = 1'b1;
        end
        if (busy) begin
          st = ST_BUSY;
        end else begin
          // hole is filled from the tail
          pixel_sum        = pixel_sum - held_pixels[pos];
          last             = held_count - 1;
          held_ident[pos]  = held_ident[last];
          held_pixels[pos] = held_pixels[last];
          held_count       = last;
        end
      end
      CMD_PRESENT: begin
        if (c.frame_serial == '0 || buffer_slot(c.buffer_ident) < 0 ||
            flight_count >= INFLIGHT_SLOTS || serial_slot(c.frame_serial) >= 0) begin
          st = ST_INVALID;
        end else begin
          flight_serial[flight_count] = c.frame_serial;
          flight_ident[flight_count]  = c.buffer_ident;
          flight_count++;
        end
      end
      default: begin
        pos = serial_slot(c.frame_serial);
        if (buffer_slot(c.buffer_ident) < 0 ||
            (c.released_ident != '0 && buffer_slot(c.released_ident) < 0) ||
            pos < 0 || flight_ident[pos] != c.buffer_ident) begin
          st = ST_PROTO;
        end else begin
          last               = flight_count - 1;
          flight_serial[pos] = flight_serial[last];
          flight_ident[pos]  = flight_ident[last];
          flight_count       = last;
        end
      end
    endcase
    r.status           = st;
    r.buffers_held     = HELD_W'(held_count);
    r.frames_in_flight = FLIGHT_W'(flight_count);
    r.pixels_held      = pixel_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content. Ids and serials come mostly from small pools so that
  // present/complete/unregister hit live entries; the rest is zero or noise.
  // ---------------------------------------------------------------------------
  function automatic logic [ID_W-1:0] pick_ident();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return {$urandom, $urandom};
    return ident_pool[$urandom_range(0, IDENT_POOL - 1)];
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(logic [DIM_W-1:0] lim);
    int r;
    int v;
    r = $urandom_range(0, 19);
    if (r < 11) return DIM_W'($urandom_range(1, 64));
    if (r < 15) begin
      // straddle the configured limit
      v = lim;
      v = v + int'($urandom_range(0, 2)) - 1;
      if (v > 65535) v = 65535;
      return DIM_W'(v);
    end
    if (r < 18) return DIM_W'($urandom_range(0, 65535));
    if (r == 18) return '0;
    return '1;
  endfunction

  function automatic command_item_t random_command(logic [DIM_W-1:0] wlim,
                                                   logic [DIM_W-1:0] hlim);
    command_item_t c;
    int            r;
    r = $urandom_range(0, 19);
    if (r < 7)       c.command = CMD_REGISTER;
    else if (r < 11) c.command = CMD_UNREGISTER;
    else if (r < 16) c.command = CMD_PRESENT;
    else             c.command = CMD_COMPLETE;
    c.buffer_ident = pick_ident();
    c.frame_width  = pick_dim(wlim);
    c.frame_height = pick_dim(hlim);
    r = $urandom_range(0, 19);
    if (r == 0)      c.frame_serial = '0;
    else if (r == 1) c.frame_serial = {$urandom, $urandom};
    else             c.frame_serial = serial_pool[$urandom_range(0, SERIAL_POOL - 1)];
    // released id: half the time none, otherwise a pool id, noise or zero
    c.released_ident = ($urandom_range(0, 1) == 0) ? '0 : pick_ident();
    return c;
  endfunction

  task automatic push_cmd(cmd_t cmd, logic [ID_W-1:0] ident, logic [DIM_W-1:0] w,
                          logic [DIM_W-1:0] h, logic [ID_W-1:0] serial,
                          logic [ID_W-1:0] released);
    command_item_t c;
    c.command        = cmd;
    c.buffer_ident   = ident;
    c.frame_width    = w;
    c.frame_height   = h;
    c.frame_serial   = serial;
    c.released_ident = released;
    pending_commands.push_back(c);
  endtask

  // Sampled on the falling edge so the driver and monitor have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_commands.size() != 0 || in_if.valid || expected_results.size() != 0);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int count, logic [DIM_W-1:0] wlim, logic [DIM_W-1:0] hlim);
    for (int n = 0; n < count; n++) pending_commands.push_back(random_command(wlim, hlim));
    wait_drained();
  endtask

  task automatic note_failure(string msg);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      note_failure($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command driver. Bursts of back-to-back items separated by random gaps.
  // The item on the bus at an accepting edge is run through the shadow model
  // at that same edge, which also takes register writes.
  // ---------------------------------------------------------------------------
  int            burst_left;
  int            gap_left;
  command_item_t accepted_cmd;
  command_item_t next_cmd;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      burst_left   = $urandom_range(1, 48);
      gap_left     = 0;
      held_count   = 0;
      flight_count = 0;
      pixel_sum    = '0;
      budget_lim   = PIXEL_BUDGET_RST;
      width_lim    = MAX_DIM_RST;
      height_lim   = MAX_DIM_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PIXEL_BUDGET: budget_lim = cfg_wdata[PIX_W-1:0];
          CFG_MAX_WIDTH:    width_lim  = cfg_wdata[DIM_W-1:0];
          CFG_MAX_HEIGHT:   height_lim = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end

      if (in_if.valid && in_if.ready) begin
        accepted_cmd.command        = cmd_t'(in_if.command);
        accepted_cmd.buffer_ident   = in_if.buffer_ident;
        accepted_cmd.frame_width    = in_if.frame_width;
        accepted_cmd.frame_height   = in_if.frame_height;
        accepted_cmd.frame_serial   = in_if.frame_serial;
        accepted_cmd.released_ident = in_if.released_ident;
        expected_results.push_back(predict_session_result(accepted_cmd));
      end

      // bus is free for a new item unless the current one is still stalled
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          next_cmd = pending_commands.pop_front();
          in_if.valid          <= 1'b1;
          in_if.command        <= next_cmd.command;
          in_if.buffer_ident   <= next_cmd.buffer_ident;
          in_if.frame_width    <= next_cmd.frame_width;
          in_if.frame_height   <= next_cmd.frame_height;
          in_if.frame_serial   <= next_cmd.frame_serial;
          in_if.released_ident <= next_cmd.released_ident;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready follows a randomly chosen mode, picked anew after a random window
  // (always ready, coin flip, mostly stalled, strict alternation).
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_window;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode      = 0;
      rx_window    = 0;
    end else begin
      if (rx_window == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_window = $urandom_range(16, 96);
      end else begin
        rx_window--;
      end
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 0);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ~out_if.ready;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  session_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d held %0d flight %0d px %0d",
                               out_if.status, out_if.buffers_held,
                               out_if.frames_in_flight, out_if.pixels_held));
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_if.status);
        check_field("buffers_held", want.buffers_held, out_if.buffers_held);
        check_field("frames_in_flight", want.frames_in_flight, out_if.frames_in_flight);
        check_field("pixels_held", want.pixels_held, out_if.pixels_held);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Each phase drains completely before its limits are rewritten,
  // which also gives the required full-drain pause on the input side.
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count       = 0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_REGISTER;
    in_if.buffer_ident   = '0;
    in_if.frame_width    = '0;
    in_if.frame_height   = '0;
    in_if.frame_serial   = '0;
    in_if.released_ident = '0;
    out_if.ready         = 1'b0;

    // small id/serial pools with both extremes and random bodies
    ident_pool[0] = 64'd1;
    ident_pool[1] = ID_TOP;
    ident_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < IDENT_POOL; i++) ident_pool[i] = {$urandom, $urandom};
    serial_pool[0] = 64'd1;
    serial_pool[1] = ID_TOP;
    for (int i = 2; i < SERIAL_POOL; i++) serial_pool[i] = {$urandom, $urandom};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset limits: 16384 x 16384, budget 2^26 ---
    // register argument checks
    push_cmd(CMD_REGISTER, '0, 16'd1, 16'd1, '0, '0);           // zero id
    push_cmd(CMD_REGISTER, ID_TOP, 16'd0, 16'd1, '0, '0);       // zero width
    push_cmd(CMD_REGISTER, ID_TOP, 16'd1, 16'd0, '0, '0);       // zero height
    push_cmd(CMD_REGISTER, ID_TOP, 16'd16385, 16'd1, '0, '0);   // width over limit
    push_cmd(CMD_REGISTER, ID_TOP, 16'd1, 16'hFFFF, '0, '0);    // height over limit
    for (int k = 1; k <= 7; k++) push_cmd(CMD_REGISTER, ID_W'(k), 16'd1, 16'd1, '0, '0);
    push_cmd(CMD_REGISTER, 64'd1, 16'd2, 16'd2, '0, '0);        // duplicate id
    push_cmd(CMD_REGISTER, ID_TOP, 16'd16384, 16'd4096, '0, '0); // 2^26 + 7: over budget
    push_cmd(CMD_REGISTER, ID_TOP, 16'd16384, 16'd4095, '0, '0); // fits, table full
    push_cmd(CMD_REGISTER, 64'd9, 16'd1, 16'd1, '0, '0);        // no free slot
    push_cmd(CMD_UNREGISTER, 64'd99, '0, '0, '0, '0);           // unknown id
    // present checks
    push_cmd(CMD_PRESENT, 64'd1, '0, '0, '0, '0);               // zero serial
    push_cmd(CMD_PRESENT, 64'd99, '0, '0, 64'd5, '0);           // unknown buffer
    push_cmd(CMD_PRESENT, 64'd1, '0, '0, ID_TOP, '0);
    push_cmd(CMD_PRESENT, 64'd2, '0, '0, 64'd2, '0);
    push_cmd(CMD_PRESENT, 64'd3, '0, '0, 64'd2, '0);            // serial already in flight
    push_cmd(CMD_PRESENT, ID_TOP, '0, '0, 64'd3, '0);
    push_cmd(CMD_PRESENT, 64'd3, '0, '0, 64'd4, '0);
    push_cmd(CMD_PRESENT, 64'd4, '0, '0, 64'd6, '0);            // in-flight table full
    push_cmd(CMD_UNREGISTER, 64'd1, '0, '0, '0, '0);            // buffer still in flight
    // complete checks
    push_cmd(CMD_COMPLETE, 64'd99, '0, '0, 64'd2, '0);          // unknown buffer
    push_cmd(CMD_COMPLETE, 64'd2, '0, '0, 64'd2, 64'd99);       // unknown released id
    push_cmd(CMD_COMPLETE, 64'd2, '0, '0, 64'd77, '0);          // serial not in flight
    push_cmd(CMD_COMPLETE, 64'd1, '0, '0, 64'd2, '0);           // serial on other buffer
    push_cmd(CMD_COMPLETE, 64'd1, '0, '0, ID_TOP, ID_TOP);      // good, head slot refilled
    push_cmd(CMD_UNREGISTER, 64'd1, '0, '0, '0, '0);            // now free to go
    wait_drained();

    run_random(230, MAX_DIM_RST, MAX_DIM_RST);

    // widest limits; height data carries junk above bit 15
    write_setting(CFG_PIXEL_BUDGET, 32'hFFFF_FFFF);
    write_setting(CFG_MAX_WIDTH, 32'h0000_FFFF);
    write_setting(CFG_MAX_HEIGHT, 32'hFFFF_FFFF);
    run_random(230, 16'hFFFF, 16'hFFFF);

    // tightest limits: a zero budget rejects every register
    write_setting(CFG_PIXEL_BUDGET, 32'd0);
    write_setting(CFG_MAX_WIDTH, 32'd1);
    write_setting(CFG_MAX_HEIGHT, 32'hABCD_0001);
    run_random(120, 16'd1, 16'd1);

    // dead index must not disturb anything
    write_setting(CFG_UNUSED_IDX, 32'h1234_5678);
    write_setting(CFG_PIXEL_BUDGET, 32'd6000);
    write_setting(CFG_MAX_WIDTH, 32'h0001_0064);
    write_setting(CFG_MAX_HEIGHT, 32'd48);
    run_random(240, 16'd100, 16'd48);

    write_setting(CFG_PIXEL_BUDGET, CFG_DATA_W'($urandom_range(2000, 200000)));
    write_setting(CFG_MAX_WIDTH, 32'd300);
    write_setting(CFG_MAX_HEIGHT, 32'd16384);
    run_random(230, 16'd300, 16'd16384);

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
